>>> rtl/crls_pkg.sv
// Shared types, constants and helpers for the chainable RGB LED frame sender.
// No dependencies; imported by crls_ctrl, crls_datapath and the top level.

package crls_pkg;

    localparam int unsigned C_MAX_LEDS = 16;
    localparam int unsigned LEDCNT_W   = 5;
    localparam int unsigned IDX_IN_W   = 4;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned COLOUR_W   = 3 * LEVEL_W;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned S_TDATA_W  = 32;

    localparam logic [WORD_W-1:0] C_ZERO_WORD = '0;

    typedef enum logic [1:0] {
        SEL_START = 2'd0,
        SEL_LED   = 2'd1,
        SEL_END   = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     store_wr;
        logic     cnt_clr;
        logic     rd_issue;
        logic     cnt_inc;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_last;
        logic out_free;
    } t_dp_stat;

    // entry layout: blue[23:16], green[15:8], red[7:0]
    function automatic logic [WORD_W-1:0] colour_word(input logic [COLOUR_W-1:0] c);
        logic [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0] g;
        logic [LEVEL_W-1:0] b;
        r = c[LEVEL_W-1:0];
        g = c[2*LEVEL_W-1:LEVEL_W];
        b = c[3*LEVEL_W-1:2*LEVEL_W];
        return {2'b11, ~b[7], ~b[6], ~g[7], ~g[6], ~r[7], ~r[6], b, g, r};
    endfunction

endpackage

>>> rtl/crls_ctrl.sv
// Frame sequencer state machine for the LED frame sender.
// Depends on crls_pkg; drives crls_datapath through t_dp_cmd / t_dp_stat.

module crls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  crls_pkg::t_dp_stat i_stat,
    output crls_pkg::t_dp_cmd  o_cmd
);
    import crls_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_READ  = 5'b00100,
        S_LED   = 5'b01000,
        S_END   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_sel = SEL_START;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store_wr = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = S_START;
                end
            end
            S_START: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = SEL_START;
                    n_state        = i_stat.cnt_zero ? S_END : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LED;
            end
            S_LED: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = SEL_LED;
                    o_cmd.cnt_inc  = 1'b1;
                    n_state        = i_stat.cnt_last ? S_END : S_READ;
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = SEL_END;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_START))
        else $error("accepted transaction did not start a frame");

    a_end_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.out_sel == SEL_END) |=> (r_state == S_IDLE))
        else $error("end word loaded without returning to idle");

    a_last_led_to_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LED && i_stat.out_free && i_stat.cnt_last) |=> (r_state == S_END))
        else $error("last LED word not followed by end word");

endmodule

>>> rtl/crls_datapath.sv
// Colour store, LED counter, count register and output register.
// Depends on crls_pkg; commanded by crls_ctrl.

module crls_datapath #(
    parameter int unsigned MAX_LEDS = crls_pkg::C_MAX_LEDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [crls_pkg::LEDCNT_W-1:0]   i_cfg_data,
    input  logic [crls_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [crls_pkg::WORD_W-1:0]     o_m_tdata,
    output logic                            o_m_tlast,
    input  crls_pkg::t_dp_cmd               i_cmd,
    output crls_pkg::t_dp_stat              o_stat
);
    import crls_pkg::*;

    localparam int unsigned IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int unsigned CAP   = (MAX_LEDS < 31) ? MAX_LEDS : 31;
    localparam logic [LEDCNT_W-1:0] CAP_CNT = CAP[LEDCNT_W-1:0];

    logic [LEDCNT_W-1:0] r_leds;
    logic [LEDCNT_W-1:0] eff_cnt;
    logic [LEDCNT_W-1:0] r_cnt;

    logic [COLOUR_W-1:0] mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] r_valid;
    logic [COLOUR_W-1:0] r_rd_data;
    logic                r_rd_vld;

    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_data;
    logic                r_out_last;

    logic [IDX_IN_W-1:0]       in_idx;
    logic [COLOUR_W-1:0]       in_colour;
    logic                      in_use;
    logic [IDX_W+IDX_IN_W-1:0] wr_wide;
    logic [IDX_W-1:0]          wr_addr;
    logic [IDX_W+LEDCNT_W-1:0] rd_wide;
    logic [IDX_W-1:0]          rd_addr;
    logic                      store_we;
    logic                      out_free;
    logic [WORD_W-1:0]         led_word;

    assign eff_cnt   = (r_leds > CAP_CNT) ? CAP_CNT : r_leds;
    assign in_idx    = i_s_tdata[IDX_IN_W-1:0];
    assign in_colour = {i_s_tdata[IDX_IN_W+3*LEVEL_W-1:IDX_IN_W+2*LEVEL_W],
                        i_s_tdata[IDX_IN_W+2*LEVEL_W-1:IDX_IN_W+LEVEL_W],
                        i_s_tdata[IDX_IN_W+LEVEL_W-1:IDX_IN_W]};
    assign in_use    = ({1'b0, in_idx} < eff_cnt);
    assign store_we  = i_cmd.store_wr && in_use;
    assign wr_wide   = {{IDX_W{1'b0}}, in_idx};
    assign wr_addr   = wr_wide[IDX_W-1:0];
    assign rd_wide   = {{IDX_W{1'b0}}, r_cnt};
    assign rd_addr   = rd_wide[IDX_W-1:0];
    assign out_free  = !r_out_valid || i_m_tready;
    assign led_word  = colour_word(r_rd_vld ? r_rd_data : '0);

    assign o_stat.cnt_zero = (eff_cnt == '0);
    assign o_stat.cnt_last = (r_cnt == eff_cnt - 1'b1);
    assign o_stat.out_free = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leds <= LEDCNT_W'(1);
        end else if (i_cfg_valid) begin
            r_leds <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            mem[wr_addr] <= in_colour;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (store_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_issue) begin
                r_rd_vld <= r_valid[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                SEL_START: begin
                    r_out_data <= C_ZERO_WORD;
                    r_out_last <= 1'b0;
                end
                SEL_LED: begin
                    r_out_data <= led_word;
                    r_out_last <= 1'b0;
                end
                SEL_END: begin
                    r_out_data <= C_ZERO_WORD;
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_data <= C_ZERO_WORD;
                    r_out_last <= 1'b0;
                end
            endcase
        end
    end

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register overwritten while holding a word");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_cnt < eff_cnt))
        else $error("store read beyond LEDs in use");

    a_end_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_data == C_ZERO_WORD))
        else $error("end word is not zero");

endmodule

>>> rtl/chainable_rgb_led_frame_sender_core.sv
// Top level of the chainable RGB LED frame sender.
// Depends on crls_pkg, crls_ctrl and crls_datapath.

// Each accepted transaction updates one LED colour (if its index is below the
// effective LED count, min(leds_in_chain, MAX_LEDS)) and then sends a frame of
// 32-bit words: a zero start word, one colour word per LED in use (LED 0
// first), and a zero end word marked by tlast. Every colour word costs one
// registered read of the colour store plus one output load. The next
// transaction is taken once the end word sits in the output register.
// The colour store reads as zero after reset through per-entry valid flags,
// so no clearing pass is needed. The count register is written over the cfg
// channel, which is always ready; write it only while the block is idle.

module chainable_rgb_led_frame_sender_core #(
    parameter int unsigned MAX_LEDS = crls_pkg::C_MAX_LEDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [crls_pkg::LEDCNT_W-1:0]   i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [3:0] led_index, [11:4] red_level, [19:12] green_level,
    // [27:20] blue_level, [31:28] zero
    input  logic [crls_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [31:0] frame_word
    output logic [crls_pkg::WORD_W-1:0]     o_m_tdata,
    output logic                            o_m_tlast
);
    import crls_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    crls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    crls_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for chainable_rgb_led_frame_sender_core: drives colour
// updates and chain-length writes and checks every frame word and tlast.
// Depends on crls_pkg and the RTL of the frame sender only.

module tb;
    import crls_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned REPORT_MAX = 10;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is_end;
    } t_frame_beat;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LEDCNT_W-1:0]  i_cfg_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [WORD_W-1:0]    o_m_tdata;
    logic                 o_m_tlast;

    // predictor state
    logic [COLOUR_W-1:0] led_colours [C_MAX_LEDS];
    logic [LEDCNT_W-1:0] chain_len;
    t_frame_beat         pending_words [$];

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned words_checked = 0;
    int unsigned frames_checked = 0;
    int unsigned cfg_writes = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_req_len = 0;
    int unsigned hold_req_seq = 0;
    int unsigned hold_seen_seq = 0;
    int unsigned hold_left = 0;

    chainable_rgb_led_frame_sender_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     pending_words.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sink: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_req_seq != hold_seen_seq) begin
            hold_seen_seq = hold_req_seq;
            hold_left = hold_req_len;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic logic [WORD_W-1:0] led_word(input logic [COLOUR_W-1:0] c);
        logic [7:0] red;
        logic [7:0] grn;
        logic [7:0] blu;
        logic [7:0] flag;
        red = c[7:0];
        grn = c[15:8];
        blu = c[23:16];
        flag = {2'b11, ~{blu[7:6], grn[7:6], red[7:6]}};
        return {flag, blu, grn, red};
    endfunction

    // update the colour store and queue the frame this transaction produces
    task automatic predict_frame(input logic [S_TDATA_W-1:0] item);
        int unsigned in_use;
        logic [3:0]  idx;
        idx = item[3:0];
        in_use = (chain_len > C_MAX_LEDS) ? C_MAX_LEDS : chain_len;
        if (idx < in_use)
            led_colours[idx] = {item[27:20], item[19:12], item[11:4]};
        pending_words.push_back('{word: C_ZERO_WORD, is_end: 1'b0});
        for (int unsigned n = 0; n < in_use; n++)
            pending_words.push_back('{word: led_word(led_colours[n]), is_end: 1'b0});
        pending_words.push_back('{word: C_ZERO_WORD, is_end: 1'b1});
    endtask

    // monitor: inputs first so a same-edge result always finds its expectation
    always @(posedge i_clk) begin
        t_frame_beat exp_beat;
        if (!i_rst_n) begin
            for (int n = 0; n < C_MAX_LEDS; n++)
                led_colours[n] = '0;
            chain_len = 5'd1;
            pending_words.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                chain_len = i_cfg_data;
            if (i_s_tvalid && o_s_tready)
                predict_frame(i_s_tdata);
            if (o_m_tvalid && i_m_tready) begin
                if (pending_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected word %h last=%b", o_m_tdata, o_m_tlast);
                end else begin
                    exp_beat = pending_words.pop_front();
                    words_checked++;
                    if (exp_beat.is_end)
                        frames_checked++;
                    if (o_m_tdata !== exp_beat.word || o_m_tlast !== exp_beat.is_end) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("word mismatch: expected %h last=%b, got %h last=%b",
                                     exp_beat.word, exp_beat.is_end, o_m_tdata, o_m_tlast);
                    end
                end
            end
        end
    end

    task automatic send_colour(input logic [3:0] idx, input logic [7:0] red,
                               input logic [7:0] grn, input logic [7:0] blu);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {4'b0000, blu, grn, red, idx};
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_chain_len(input logic [LEDCNT_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic send_random_colour();
        int unsigned in_use;
        logic [3:0]  idx;
        in_use = (chain_len > C_MAX_LEDS) ? C_MAX_LEDS : chain_len;
        if (in_use != 0 && $urandom_range(99) < 75)
            idx = 4'($urandom_range(in_use - 1));
        else
            idx = 4'($urandom_range(15));
        send_colour(idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
    endtask

    task automatic test_level_extremes();
        send_colour(4'd0, 8'hFF, 8'hFF, 8'hFF);
        send_colour(4'd15, 8'h12, 8'h34, 8'h56);
        send_colour(4'd1, 8'hAA, 8'hAA, 8'hAA);
        write_chain_len(5'd16);
        send_colour(4'd0, 8'h00, 8'h00, 8'h00);
        send_colour(4'd15, 8'hFF, 8'h00, 8'h80);
        send_colour(4'd7, 8'h80, 8'h40, 8'hC0);
        send_colour(4'd8, 8'h40, 8'hC0, 8'h3F);
        send_colour(4'd3, 8'h7F, 8'hBF, 8'h01);
        send_colour(4'd15, 8'h00, 8'hFF, 8'h40);
    endtask

    task automatic test_chain_len_limits();
        write_chain_len(5'd0);
        send_colour(4'd0, 8'h11, 8'h22, 8'h33);
        send_colour(4'd15, 8'hFF, 8'hFF, 8'hFF);
        write_chain_len(5'd31);
        send_colour(4'd15, 8'h5A, 8'hA5, 8'hC3);
        send_colour(4'd0, 8'h3C, 8'h96, 8'h69);
        write_chain_len(5'd17);
        send_colour(4'd14, 8'h01, 8'h02, 8'h04);
        write_chain_len(5'd1);
        send_colour(4'd1, 8'hFE, 8'hFD, 8'hFB);
        send_colour(4'd0, 8'h08, 8'h10, 8'h20);
        write_chain_len(5'd5);
        send_colour(4'd4, 8'hE7, 8'h18, 8'h81);
        send_colour(4'd5, 8'h42, 8'h24, 8'h99);
    endtask

    task automatic test_random_traffic();
        int unsigned src_pct [4] = '{0, 60, 0, 34};
        int unsigned sink_pct [4] = '{0, 0, 60, 34};
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_chain_len(5'd16);
                1: write_chain_len(5'($urandom_range(2, 15)));
                2: write_chain_len(5'($urandom_range(0, 31)));
                default: write_chain_len(5'd16);
            endcase
            src_idle_pct = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            repeat (25) send_random_colour();
        end
        src_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    task automatic test_sink_hold_off();
        write_chain_len(5'd16);
        hold_req_len = 400;
        hold_req_seq++;
        repeat (8) send_random_colour();
        wait_drained();
        repeat (4) send_random_colour();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_level_extremes();
        test_chain_len_limits();
        test_random_traffic();
        test_sink_hold_off();
        wait_drained();
        $display("%0d colour updates, %0d chain-length writes, %0d frames / %0d words checked",
                 items_sent, cfg_writes, frames_checked, words_checked);
        $display("covered chain lengths 0 to 31, idle and stall phases, long sink hold-off");
        if (fail_count == 0 && pending_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d failures, %0d words never seen", fail_count, pending_words.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/crls_pkg.sv
rtl/crls_ctrl.sv
rtl/crls_datapath.sv
rtl/chainable_rgb_led_frame_sender_core.sv
tb/tb.sv
